// ----- sv/irot_pkg.sv -----
package irot_pkg;

  localparam int CFG_W    = 8;
  localparam int PIX_W    = 8;
  localparam int REQ_W    = 3;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 3'd0,
    REQ_ROT_CW  = 3'd1,
    REQ_ROT_ACW = 3'd2,
    REQ_READ    = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_t;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [1:0] TURN_0   = 2'd0;
  localparam logic [1:0] TURN_90  = 2'd1;
  localparam logic [1:0] TURN_180 = 2'd2;
  localparam logic [1:0] TURN_270 = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic rot_cw;
    logic rot_acw;
    logic rd;
    logic clr;
    logic out_load;
  } cmd_t;

endpackage

// ----- sv/irot_if.sv -----
interface irot_in_if;
  import irot_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [PIX_W-1:0] pixel_in;

  modport source (output valid, output req_type, output pixel_in, input ready);
  modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

interface irot_out_if;
  import irot_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_out;
  logic                    last_pixel;
  logic                    invalid_seen;
  logic [1:0]              orientation;

  modport source (output valid, output pixel_out, output last_pixel,
                  output invalid_seen, output orientation, input ready);
  modport sink (input valid, input pixel_out, input last_pixel,
                input invalid_seen, input orientation, output ready);
endinterface

// ----- sv/image_rotate_90_top.sv -----
// Frame store that returns its image turned by quarter turns.
// The input channel carries one request per item: load pixel, rotate
// clockwise, rotate anticlockwise, read next, or clear. Loads fill the store
// in source raster order up to rows times columns pixels; further loads are
// dropped. Rotate requests step the orientation and restart the read
// position. Each read request yields one item on the output channel with
// the pixel of the rotated frame, a last-pixel mark, the sticky bad-pixel
// flag and the current orientation. The APB port sets the source rows and
// columns and should be written only while the block is idle.
// A load, rotate or clear request is acted on as it is taken and the next
// request is taken in the following cycle. A read request passes the registered
// read port of the pixel memory and then the output register; no request is
// taken between the two. The output register holds one result; other requests
// are still taken while it waits, but a read stays in the read state, taking
// no requests, until the output register is free.
// Reset clears the counters, orientation, flag and output valid, and sets
// both dimensions to one; the stored pixels are not cleared.
module image_rotate_90_top import irot_pkg::*; #(
  parameter int MAX_SIDE   = 128,
  parameter int PIXEL_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  irot_in_if.sink           in_chan,
  irot_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cmd_t cmd;

  assign pready = 1'b1;

  irot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_req    (in_chan.req_type),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd)
  );

  irot_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_pixel    (in_chan.pixel_in),
    .out_pixel   (out_chan.pixel_out),
    .out_last    (out_chan.last_pixel),
    .out_invalid (out_chan.invalid_seen),
    .out_orient  (out_chan.orientation),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
  );

endmodule

// ----- sv/irot_ctrl.sv -----
module irot_ctrl import irot_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] in_req,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output cmd_t             cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req)
            REQ_LOAD:    cmd.load    = 1'b1;
            REQ_ROT_CW:  cmd.rot_cw  = 1'b1;
            REQ_ROT_ACW: cmd.rot_acw = 1'b1;
            REQ_CLEAR:   cmd.clr     = 1'b1;
            REQ_READ: begin
              cmd.rd    = 1'b1;
              state_nxt = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/irot_dp.sv -----
module irot_dp import irot_pkg::*; #(
  parameter int MAX_SIDE   = 128,
  parameter int PIXEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic signed [PIX_W-1:0] in_pixel,
  output logic signed [PIX_W-1:0] out_pixel,
  output logic                    out_last,
  output logic                    out_invalid,
  output logic [1:0]              out_orient,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata
);

  localparam int DW    = $clog2(MAX_SIDE + 1);
  localparam int SW    = $clog2(MAX_SIDE);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int FW    = 2 * DW;
  localparam int CW    = (DW > CFG_W) ? DW : CFG_W;
  localparam int XW    = (PIXEL_BITS > PIX_W) ? PIXEL_BITS : PIX_W;
  localparam int PW    = SW + DW;

  logic [CFG_W-1:0]      rows_r, cols_r;
  logic [LW-1:0]         load_cnt_r;
  logic [SW-1:0]         row_r, col_r;
  logic [1:0]            turns_r;
  logic                  bad_r;
  logic                  last_r;
  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] mem_q;

  logic [CW-1:0]         rows_ext, cols_ext;
  logic [DW-1:0]         rows_d, cols_d, h, w;
  logic [FW-1:0]         frame;
  logic                  outside;
  logic [SW-1:0]         i, j, r, c;
  logic [DW-1:0]         i1, j1;
  logic [PW-1:0]         addr_sum;
  logic [AW-1:0]         rd_addr;
  logic                  last;
  logic                  do_store;
  logic signed [XW-1:0]  pix_ext, q_ext;
  logic [PIXEL_BITS-1:0] pix_raw;
  logic                  pix_ok;
  logic                  cfg_we;

  assign cfg_we   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_COLS) ? APB_DW'(cols_r) : APB_DW'(rows_r);

  assign rows_ext = CW'(rows_r);
  assign cols_ext = CW'(cols_r);

  always_comb begin
    if (rows_ext == '0) begin
      rows_d = DW'(1);
    end else if (rows_ext > CW'(MAX_SIDE)) begin
      rows_d = DW'(MAX_SIDE);
    end else begin
      rows_d = DW'(rows_ext);
    end
    if (cols_ext == '0) begin
      cols_d = DW'(1);
    end else if (cols_ext > CW'(MAX_SIDE)) begin
      cols_d = DW'(MAX_SIDE);
    end else begin
      cols_d = DW'(cols_ext);
    end
  end

  assign frame    = FW'(rows_d) * FW'(cols_d);
  assign h        = turns_r[0] ? cols_d : rows_d;
  assign w        = turns_r[0] ? rows_d : cols_d;
  assign outside  = (DW'(row_r) >= h) || (DW'(col_r) >= w);
  assign i        = outside ? '0 : row_r;
  assign j        = outside ? '0 : col_r;
  assign i1       = DW'(i) + DW'(1);
  assign j1       = DW'(j) + DW'(1);
  assign last     = (DW'(i) == h - DW'(1)) && (DW'(j) == w - DW'(1));

  always_comb begin
    case (turns_r)
      TURN_0: begin
        r = i;
        c = j;
      end
      TURN_90: begin
        r = SW'(rows_d - DW'(1) - DW'(j));
        c = i;
      end
      TURN_180: begin
        r = SW'(rows_d - DW'(1) - DW'(i));
        c = SW'(cols_d - DW'(1) - DW'(j));
      end
      default: begin
        r = j;
        c = SW'(cols_d - DW'(1) - DW'(i));
      end
    endcase
  end

  assign addr_sum = PW'(r) * PW'(cols_d) + PW'(c);
  assign rd_addr  = AW'(addr_sum);

  assign pix_ext  = XW'(in_pixel);
  assign pix_raw  = pix_ext[PIXEL_BITS-1:0];
  assign pix_ok   = (pix_raw == '0) || (pix_raw == PIXEL_BITS'(1)) || (pix_raw == '1);
  assign do_store = cmd.load && (FW'(load_cnt_r) < frame);
  assign q_ext    = XW'($signed(mem_q));

  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[load_cnt_r[AW-1:0]] <= pix_raw;
    end
    if (cmd.rd) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      last_r <= last;
    end
    if (cmd.out_load) begin
      out_pixel   <= q_ext[PIX_W-1:0];
      out_last    <= last_r;
      out_invalid <= bad_r;
      out_orient  <= turns_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= CFG_W'(1);
      cols_r     <= CFG_W'(1);
      load_cnt_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      turns_r    <= TURN_0;
      bad_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (paddr[2] == REG_COLS) begin
          cols_r <= pwdata[CFG_W-1:0];
        end else begin
          rows_r <= pwdata[CFG_W-1:0];
        end
      end
      if (do_store) begin
        load_cnt_r <= load_cnt_r + LW'(1);
        if (!pix_ok) begin
          bad_r <= 1'b1;
        end
      end
      if (cmd.rot_cw || cmd.rot_acw) begin
        turns_r <= cmd.rot_cw ? turns_r + 2'd1 : turns_r - 2'd1;
        row_r   <= '0;
        col_r   <= '0;
      end
      if (cmd.clr) begin
        load_cnt_r <= '0;
        row_r      <= '0;
        col_r      <= '0;
        turns_r    <= TURN_0;
        bad_r      <= 1'b0;
      end
      if (cmd.rd) begin
        if (j1 < w) begin
          col_r <= SW'(j1);
          row_r <= i;
        end else begin
          col_r <= '0;
          row_r <= (i1 < h) ? SW'(i1) : '0;
        end
      end
    end
  end

endmodule

// ----- sv/irot_checker.sv -----
module irot_checker import irot_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [REQ_W-1:0] in_req,
  input logic             out_valid,
  input logic             out_ready
);

  logic rd_acc;
  logic other_acc;

  assign rd_acc    = in_valid && in_ready && (in_req == REQ_READ);
  assign other_acc = in_valid && in_ready && (in_req != REQ_READ);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before it was taken");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_acc |=> !in_ready)
    else $error("request taken in the cycle after a read");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    rd_acc && !out_valid |-> ##2 out_valid)
    else $error("read result did not appear two cycles after the read");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    other_acc && !out_valid |=> !out_valid)
    else $error("result appeared for a request that gives none");

endmodule

bind image_rotate_90_top irot_checker u_irot_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_req    (in_chan.req_type),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);
